FILE: hw/rtl/glu_pkg.sv
// ----------------------------------------------------------------------------
// glu_pkg
// Shared types and constants for the gcd / lcm unit: operation codes,
// controller states and the command / status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package glu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(DATA_W);
  localparam int unsigned PROD_W = 2 * DATA_W;

  typedef logic [DATA_W-1:0] glu_word_t;

  // Operation code carried with each input beat
  typedef enum logic {
    OP_GCD = 1'b0,
    OP_LCM = 1'b1
  } glu_op_t;

  // Source of the final result
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_OR,
    RES_X,
    RES_PROD
  } glu_res_t;

  // Divider operand selection
  typedef enum logic {
    DIV_MOD,
    DIV_QUO
  } glu_div_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TEST,
    S_MDIV,
    S_MSWAP,
    S_QDIV,
    S_MUL,
    S_FIN
  } glu_state_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    glu_div_t div_sel;
    logic     div_step;
    logic     swap;
    logic     fin_load;
    glu_res_t fin_sel;
    logic     out_load;
  } glu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    glu_op_t op;
    logic    a_zero;
    logic    b_zero;
    logic    y_zero;
    logic    div_last;
    logic    out_free;
  } glu_sts_t;

endpackage

FILE: hw/rtl/glu_if.sv
// ----------------------------------------------------------------------------
// glu_if
// Valid / ready channels of the gcd / lcm unit: operand beats in, result
// beats out.
// ----------------------------------------------------------------------------
interface glu_in_if;
  logic                valid;
  logic                ready;
  glu_pkg::glu_op_t    operation;
  glu_pkg::glu_word_t  operand_a;
  glu_pkg::glu_word_t  operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

interface glu_out_if;
  logic                valid;
  logic                ready;
  glu_pkg::glu_word_t  result;
  logic                overflow;

  modport source (output valid, output result, output overflow, input ready);
  modport sink   (input valid, input result, input overflow, output ready);
endinterface

FILE: hw/rtl/glu_dp.sv
// ----------------------------------------------------------------------------
// glu_dp
// Datapath: operand registers, Euclid pair, shared radix-2 restoring
// divider, 32x32 multiplier into the result stage, and the output register.
// ----------------------------------------------------------------------------
module glu_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  glu_pkg::glu_op_t    in_operation,
  input  glu_pkg::glu_word_t  in_operand_a,
  input  glu_pkg::glu_word_t  in_operand_b,
  input  glu_pkg::glu_cmd_t   cmd,
  output glu_pkg::glu_sts_t   sts,
  input  logic                out_ready,
  output logic                out_valid,
  output glu_pkg::glu_word_t  out_result,
  output logic                out_overflow
);
  import glu_pkg::*;

  glu_op_t          op_r;
  glu_word_t        a_r, b_r;
  glu_word_t        x_r, y_r;
  glu_word_t        rem_r, quo_r, dsr_r;
  logic [CNT_W-1:0] cnt_r;
  glu_word_t        fin_res_r;
  logic             fin_ovf_r;
  logic             out_valid_r, out_valid_nxt;
  glu_word_t        out_res_r;
  logic             out_ovf_r;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic              take;
  logic [PROD_W-1:0] prod;

  // Divider step: shift in the next dividend bit, subtract when it fits
  assign rem_sh  = {rem_r, quo_r[DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign take    = (rem_sh >= {1'b0, dsr_r});

  // lcm product: quotient a/gcd times b
  assign prod = PROD_W'(quo_r) * PROD_W'(b_r);

  // Status to controller
  assign sts.op       = op_r;
  assign sts.a_zero   = (a_r == '0);
  assign sts.b_zero   = (b_r == '0);
  assign sts.y_zero   = (y_r == '0);
  assign sts.div_last = (cnt_r == CNT_W'(DATA_W - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  // Operand capture and Euclid pair
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      a_r  <= in_operand_a;
      b_r  <= in_operand_b;
      x_r  <= in_operand_a;
      y_r  <= in_operand_b;
    end else if (cmd.swap) begin
      x_r <= y_r;
      y_r <= rem_r;
    end
  end

  // Shared divider
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      cnt_r <= '0;
      if (cmd.div_sel == DIV_MOD) begin
        quo_r <= x_r;
        dsr_r <= y_r;
      end else begin
        quo_r <= a_r;
        dsr_r <= x_r;
      end
    end else if (cmd.div_step) begin
      rem_r <= take ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], take};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Final result selection
  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      case (cmd.fin_sel)
        RES_ZERO: begin
          fin_res_r <= '0;
          fin_ovf_r <= 1'b0;
        end
        RES_OR: begin
          fin_res_r <= a_r | b_r;
          fin_ovf_r <= 1'b0;
        end
        RES_X: begin
          fin_res_r <= x_r;
          fin_ovf_r <= 1'b0;
        end
        RES_PROD: begin
          fin_res_r <= prod[DATA_W-1:0];
          fin_ovf_r <= |prod[PROD_W-1:DATA_W];
        end
        default: begin
          fin_res_r <= '0;
          fin_ovf_r <= 1'b0;
        end
      endcase
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res_r <= fin_res_r;
      out_ovf_r <= fin_ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_result   = out_res_r;
  assign out_overflow = out_ovf_r;

  // Each remainder step leaves a strictly smaller pair
  a_swap_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap |=> (y_r < x_r))
    else $error("Euclid pair did not shrink after swap");

  // Only the product path can raise overflow
  a_ovf_src: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin_load && cmd.fin_sel != RES_PROD) |=> !fin_ovf_r)
    else $error("overflow set outside the lcm product");

  // A held result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register loaded while a beat is waiting");

endmodule

FILE: hw/rtl/glu_ctrl.sv
// ----------------------------------------------------------------------------
// glu_ctrl
// Controller: sequences zero checks, Euclid remainder steps on the shared
// divider, the lcm quotient and product, and hand-off to the output stage.
// ----------------------------------------------------------------------------
module glu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  glu_pkg::glu_sts_t  sts,
  output glu_pkg::glu_cmd_t  cmd
);
  import glu_pkg::*;

  glu_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.a_zero || sts.b_zero) begin
          cmd.fin_load = 1'b1;
          cmd.fin_sel  = (sts.op == OP_GCD) ? RES_OR : RES_ZERO;
          state_nxt    = S_FIN;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (!sts.y_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MOD;
          state_nxt     = S_MDIV;
        end else if (sts.op == OP_GCD) begin
          cmd.fin_load = 1'b1;
          cmd.fin_sel  = RES_X;
          state_nxt    = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_QUO;
          state_nxt     = S_QDIV;
        end
      end
      S_MDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MSWAP;
        end
      end
      S_MSWAP: begin
        cmd.swap  = 1'b1;
        state_nxt = S_TEST;
      end
      S_QDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.fin_load = 1'b1;
        cmd.fin_sel  = RES_PROD;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // An accepted beat always goes to the zero check
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHECK))
    else $error("accepted beat did not reach the zero check");

  // A finished result waits while the output register is busy
  a_fin_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !sts.out_free) |=> (state_r == S_FIN))
    else $error("finished result left before the output was free");

endmodule

FILE: hw/rtl/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor and least common multiple of two unsigned 32-bit
// operands, Euclid's remainder loop on a shared bit-serial divider.
// Sequence: when an operand is zero the zero check hands the result straight
//   to the finish state; otherwise gcd runs k remainder steps (at most 46),
//   each a division and a swap, and lcm adds a division of a by the gcd, then the multiply.
// Throughput: one item at a time; the bit-serial divider sets the pace. A new
//   item is taken while the previous result waits in the output register.
// Reset: synchronous, active low; returns to idle and drops out valid.
// ----------------------------------------------------------------------------
module gcd_lcm_unit (
  input  logic  clk,
  input  logic  rst_n,
  glu_in_if.sink    in_ch,
  glu_out_if.source out_ch
);
  import glu_pkg::*;

  glu_cmd_t cmd;
  glu_sts_t sts;

  // Sequencer
  glu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and output stage
  glu_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_ch.operation),
    .in_operand_a (in_ch.operand_a),
    .in_operand_b (in_ch.operand_b),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_result   (out_ch.result),
    .out_overflow (out_ch.overflow)
  );

endmodule

FILE: verif/glu_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glu_result_checker
// Watches the operand and result channels of the gcd / lcm unit. Each
// accepted operand beat is run through an independent gcd / lcm predictor
// and its expected result is queued; each accepted result beat is compared
// field by field with the oldest queued one. Results with nothing queued,
// wrong fields and results still queued at the end of the run are counted
// as failures.
// ----------------------------------------------------------------------------
module glu_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        drain_done,
  glu_in_if           in_mon,
  glu_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned due_count
);
  import glu_pkg::*;

  typedef struct packed {
    glu_word_t result;
    logic      overflow;
  } glu_outcome_t;

  glu_outcome_t due_results[$];
  glu_outcome_t want;
  int unsigned  result_idx;
  logic         leftovers_seen;

  // Euclid's remainder loop, a zero operand yields the other one
  function automatic glu_word_t common_divisor(glu_word_t x, glu_word_t y);
    glu_word_t rem;
    if (x == '0) return y;
    if (y == '0) return x;
    while (y != '0) begin
      rem = x % y;
      x   = y;
      y   = rem;
    end
    return x;
  endfunction

  // gcd, or lcm as (a / gcd) * b kept to 32 bits with the carry-out flagged
  function automatic glu_outcome_t predict_outcome(glu_op_t op, glu_word_t a, glu_word_t b);
    glu_outcome_t      o;
    glu_word_t         g;
    logic [PROD_W-1:0] prod;
    o = '0;
    if (op == OP_GCD) begin
      o.result = common_divisor(a, b);
    end else if (a != '0 && b != '0) begin
      g          = common_divisor(a, b);
      prod       = PROD_W'(a / g) * PROD_W'(b);
      o.result   = prod[DATA_W-1:0];
      o.overflow = |prod[PROD_W-1:DATA_W];
    end
    return o;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Queue predictions on operand beats, compare on result beats
  always @(posedge clk) begin
    if (!rst_n) begin
      due_results.delete();
      fail_count     = 0;
      result_idx     = 0;
      leftovers_seen = 1'b0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        due_results.push_back(predict_outcome(in_mon.operation, in_mon.operand_a,
                                              in_mon.operand_b));
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("result beat %0d (%08h) with nothing due",
                                  result_idx, out_mon.result));
        end else begin
          want = due_results.pop_front();
          if (out_mon.result !== want.result)
            flag_mismatch($sformatf("result beat %0d: result %08h, expected %08h",
                                    result_idx, out_mon.result, want.result));
          if (out_mon.overflow !== want.overflow)
            flag_mismatch($sformatf("result beat %0d: overflow %b, expected %b",
                                    result_idx, out_mon.overflow, want.overflow));
        end
        result_idx++;
      end
      // anything still queued once the run has drained never arrived
      if (drain_done && !leftovers_seen) begin
        leftovers_seen = 1'b1;
        foreach (due_results[i])
          flag_mismatch($sformatf("expected result %08h never arrived", due_results[i].result));
      end
    end
    due_count = due_results.size();
  end

endmodule

FILE: verif/tb_gcd_lcm_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gcd_lcm_unit
// Drives the gcd / lcm unit with a directed set of corner operands followed
// by random beats (full-range, zero, small, common-factor, Fibonacci and
// corner operands), with bursty input, a patterned result stall and one long
// back-pressure hold. Checking is done by glu_result_checker.
// ----------------------------------------------------------------------------
module tb_gcd_lcm_unit;
  import glu_pkg::*;

  localparam int unsigned RANDOM_BEATS  = 1150;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned HOLD_CYCLES   = 4000;
  localparam int unsigned SETTLE_CYCLES = 2000;

  localparam glu_word_t WORD_MAX = '1;
  localparam glu_word_t FIB_46   = 32'd1836311903;
  localparam glu_word_t FIB_47   = 32'd2971215073;

  typedef enum {
    SINK_FREE,
    SINK_COIN,
    SINK_SPARSE,
    SINK_TOGGLE
  } sink_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        hold_off;
  logic        drain_done;
  int unsigned fail_count;
  int unsigned due_count;
  int unsigned beats_sent;
  int unsigned burst_left;

  glu_in_if  in_ch ();
  glu_out_if out_ch ();

  gcd_lcm_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  glu_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .drain_done (drain_done),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit, well above the slowest legal run
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Consecutive Fibonacci numbers F(k), F(k+1): the longest remainder chains
  function automatic void fib_pair(input int k, output glu_word_t lo, output glu_word_t hi);
    glu_word_t nxt;
    lo = '0;
    hi = 1;
    repeat (k) begin
      nxt = lo + hi;
      lo  = hi;
      hi  = nxt;
    end
  endfunction

  function automatic glu_word_t corner_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 1;
      2:       return WORD_MAX;
      3:       return WORD_MAX - 1;
      4:       return 32'h8000_0000;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Present one operand beat, hold it until taken, then maybe pause
  task automatic send_operands(glu_op_t op, glu_word_t a, glu_word_t b);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Random operand shapes; most reach the remainder loop with real content
  task automatic pick_operands(output glu_word_t a, output glu_word_t b);
    glu_word_t g;
    glu_word_t t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        a = $urandom;
        b = $urandom;
      end
      4: begin
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 2))
          0:       a = '0;
          1:       b = '0;
          default: begin
            a = '0;
            b = '0;
          end
        endcase
      end
      5: begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      6: begin
        g = $urandom_range(1, 65535);
        a = g * $urandom_range(1, 255);
        b = g * $urandom_range(1, 255);
      end
      7: begin
        fib_pair($urandom_range(1, 46), a, b);
        if ($urandom_range(0, 1)) begin
          t = a;
          a = b;
          b = t;
        end
      end
      8: begin
        a = $urandom;
        b = $urandom_range(0, 1) ? a : a * $urandom_range(2, 7);
      end
      default: begin
        a = corner_value();
        b = corner_value();
      end
    endcase
  endtask

  // Result side: stall pattern in segments, plus the long hold
  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned mode_left;
    logic        take;
    out_ch.ready <= 1'b0;
    mode      = SINK_FREE;
    mode_left = 0;
    take      = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (mode)
        SINK_FREE:   take = 1'b1;
        SINK_COIN:   take = 1'($urandom_range(0, 1));
        SINK_SPARSE: take = ($urandom_range(0, 3) == 0);
        default:     take = ~take;
      endcase
      out_ch.ready <= take && !hold_off;
    end
  end

  // Back-pressure: refuse results long enough for the unit to fill up
  initial begin
    hold_off <= 1'b0;
    wait (beats_sent >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stimulus and verdict
  initial begin
    glu_word_t a;
    glu_word_t b;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_GCD;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    rst_n           <= 1'b0;
    drain_done      <= 1'b0;
    beats_sent      = 0;
    burst_left      = 4;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero operands
    send_operands(OP_GCD, '0, '0);
    send_operands(OP_GCD, '0, WORD_MAX);
    send_operands(OP_GCD, WORD_MAX, '0);
    send_operands(OP_LCM, '0, '0);
    send_operands(OP_LCM, '0, 32'd12345);
    send_operands(OP_LCM, WORD_MAX, '0);
    // full-scale operands
    send_operands(OP_GCD, WORD_MAX, WORD_MAX);
    send_operands(OP_LCM, WORD_MAX, WORD_MAX);
    send_operands(OP_LCM, WORD_MAX, WORD_MAX - 1);
    send_operands(OP_GCD, 1, WORD_MAX);
    send_operands(OP_LCM, 1, WORD_MAX);
    // longest remainder chain
    send_operands(OP_GCD, FIB_47, FIB_46);
    send_operands(OP_LCM, FIB_46, FIB_47);
    // powers of two and bit patterns
    send_operands(OP_GCD, 32'h8000_0000, 32'h4000_0000);
    send_operands(OP_LCM, 32'h0001_0000, 32'h0001_0000);
    send_operands(OP_LCM, 32'h0001_0000, 32'h0001_0001);
    send_operands(OP_GCD, 32'hAAAA_AAAA, 32'h5555_5555);
    // lcm just fitting, and just spilling past 32 bits
    send_operands(OP_LCM, 32'h0000_FFFF, 32'h0001_0001);
    send_operands(OP_LCM, 2, 32'h8000_0000);
    send_operands(OP_LCM, 3, 32'h8000_0000);
    send_operands(OP_GCD, 12, 18);
    send_operands(OP_LCM, 4, 6);

    repeat (RANDOM_BEATS) begin
      pick_operands(a, b);
      send_operands(glu_op_t'($urandom_range(0, 1)), a, b);
    end

    // drain, then allow for a late extra beat
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (due_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/glu_pkg.sv
hw/rtl/glu_if.sv
hw/rtl/glu_dp.sv
hw/rtl/glu_ctrl.sv
hw/rtl/gcd_lcm_unit.sv
verif/glu_result_checker.sv
verif/tb_gcd_lcm_unit.sv
